// ===== rtl/mlfq_pkg.sv =====
// mlfq_pkg: sizes, record layout, mode and status codes of the scheduler core
// no dependencies
package mlfq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int NUM_LEVELS  = 3;

   localparam int IDX_W   = $clog2(QUEUE_DEPTH);
   localparam int LVL_W   = $clog2(NUM_LEVELS);
   localparam int SCAN_W  = $clog2(NUM_LEVELS + 1);
   localparam int ADDR_W  = $clog2(NUM_LEVELS * QUEUE_DEPTH);
   localparam int ID_W    = 8;
   localparam int BURST_W = 16;
   localparam int REC_W   = ID_W + BURST_W;

   localparam logic [BURST_W-1:0] THRESH_RESET = 16'd10;

   localparam logic [1:0] MODE_ADD      = 2'd0;
   localparam logic [1:0] MODE_DISPATCH = 2'd1;
   localparam logic [1:0] MODE_RESTART  = 2'd2;

   localparam logic [2:0] ST_ADDED      = 3'd0;
   localparam logic [2:0] ST_DISPATCHED = 3'd1;
   localparam logic [2:0] ST_REQ_DROP   = 3'd2;
   localparam logic [2:0] ST_ADD_FULL   = 3'd3;
   localparam logic [2:0] ST_PASS_DONE  = 3'd4;

endpackage

// ===== rtl/multilevel_feedback_queue_scheduler_core.sv =====
// multilevel feedback queue scheduler core: per-level linear queues in one record memory
// depends on mlfq_pkg
//
//   channel  direction  handshake          payload
//   req      in         req_valid/ready    mode, proc_id, burst_len, priority_req
//   rsp      out        rsp_valid/ready    status, out_id, out_burst, from_level, to_level
//   csr      in         csr_wr_en          burst_threshold
//
// one beat per cycle while rsp is not stalled; a beat passes the push stage and then the result register to reach rsp
// the accept stage scans levels and pops the head (memory read), the push stage then does the push
// the memory write and the next beat's pop share a cycle, with read bypass
// restart and unused modes finish in the accept cycle and give no rsp beat
// a stalled rsp holds one beat in the push stage before req_ready drops
// synchronous reset clears control state; the record memory is not cleared
module multilevel_feedback_queue_scheduler_core
   import mlfq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_mode,
   input  logic [ID_W-1:0]    req_proc_id,
   input  logic [BURST_W-1:0] req_burst_len,
   input  logic [1:0]         req_priority_req,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [ID_W-1:0]    rsp_out_id,
   output logic [BURST_W-1:0] rsp_out_burst,
   output logic [1:0]         rsp_from_level,
   output logic [1:0]         rsp_to_level,
   input  logic               csr_wr_en,
   input  logic [BURST_W-1:0] csr_wr_data
);

   logic [BURST_W-1:0] thresh_ff;

   logic [IDX_W-1:0]  head_ff [NUM_LEVELS];
   logic [IDX_W-1:0]  tail_ff [NUM_LEVELS];
   logic [NUM_LEVELS-1:0] ne_ff;
   logic [SCAN_W-1:0] scan_ff;
   logic [IDX_W-1:0]  head_in [NUM_LEVELS];
   logic [IDX_W-1:0]  tail_in [NUM_LEVELS];
   logic [NUM_LEVELS-1:0] ne_in;
   logic [SCAN_W-1:0] scan_in;

   // push stage
   logic               p_valid_ff, p_valid_in;
   logic [1:0]         p_mode_ff;
   logic [ID_W-1:0]    p_id_ff;
   logic [BURST_W-1:0] p_burst_ff;
   logic [1:0]         p_prio_ff;
   logic               p_found_ff, p_found_in;
   logic [LVL_W-1:0]   p_from_ff, p_from_in;

   // record memory
   logic [REC_W-1:0]  entry_mem [NUM_LEVELS*QUEUE_DEPTH];
   logic [REC_W-1:0]  mem_q_ff;
   logic              byp_ff;
   logic [REC_W-1:0]  byp_data_ff;
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [REC_W-1:0]  wr_data;

   // result register
   logic               rsp_valid_ff;
   logic [2:0]         rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]    rsp_id_ff, rsp_id_in;
   logic [BURST_W-1:0] rsp_burst_ff, rsp_burst_in;
   logic [1:0]         rsp_from_ff, rsp_from_in;
   logic [1:0]         rsp_to_ff, rsp_to_in;

   logic             s2_fire, accept;
   logic [REC_W-1:0] rec;
   logic             push_en, push_ok;
   logic [LVL_W-1:0] push_lvl, to_lvl;
   logic [IDX_W-1:0] push_idx, pop_idx;

   assign s2_fire   = p_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !p_valid_ff || s2_fire;
   assign accept    = req_valid && req_ready;
   assign rec       = byp_ff ? byp_data_ff : mem_q_ff;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      ne_in   = ne_ff;
      scan_in = scan_ff;

      // push: add record or requeue of the popped record
      if (p_from_ff == LVL_W'(NUM_LEVELS - 1)) begin
         to_lvl = '0;
      end else begin
         to_lvl = p_from_ff + LVL_W'(1);
      end
      if (rec[BURST_W-1:0] <= thresh_ff) begin
         if (p_from_ff == '0) begin
            to_lvl = LVL_W'(NUM_LEVELS - 1);
         end else begin
            to_lvl = p_from_ff - LVL_W'(1);
         end
      end
      if (p_mode_ff == MODE_ADD) begin
         push_en  = s2_fire && (int'(p_prio_ff) < NUM_LEVELS);
         push_lvl = LVL_W'(p_prio_ff);
         wr_data  = {p_id_ff, p_burst_ff};
      end else begin
         push_en  = s2_fire && p_found_ff;
         push_lvl = to_lvl;
         wr_data  = rec;
      end
      push_ok  = 1'b0;
      push_idx = '0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
         if (push_en && push_lvl == LVL_W'(l)) begin
            if (ne_ff[l]) begin
               if (tail_ff[l] != IDX_W'(QUEUE_DEPTH - 1)) begin
                  push_ok    = 1'b1;
                  push_idx   = tail_ff[l] + IDX_W'(1);
                  tail_in[l] = push_idx;
               end
            end else begin
               push_ok    = 1'b1;
               head_in[l] = '0;
               tail_in[l] = '0;
               ne_in[l]   = 1'b1;
            end
         end
      end
      wr_en   = push_ok;
      wr_addr = ADDR_W'(int'(push_lvl) * QUEUE_DEPTH + int'(push_idx));

      // scan and pop on the post-push state
      p_found_in = 1'b0;
      p_from_in  = '0;
      pop_idx    = '0;
      rd_en      = 1'b0;
      if (accept && req_mode == MODE_DISPATCH) begin
         for (int l = 0; l < NUM_LEVELS; l++) begin
            if (!p_found_in && l >= int'(scan_ff) && ne_in[l]) begin
               p_found_in = 1'b1;
               p_from_in  = LVL_W'(l);
            end
         end
         scan_in = p_found_in ? SCAN_W'(p_from_in) : SCAN_W'(NUM_LEVELS);
         rd_en   = p_found_in;
         for (int l = 0; l < NUM_LEVELS; l++) begin
            if (p_found_in && p_from_in == LVL_W'(l)) begin
               pop_idx = head_in[l];
               if (head_in[l] == tail_in[l]) begin
                  ne_in[l]   = 1'b0;
                  head_in[l] = '0;
                  tail_in[l] = '0;
               end else begin
                  head_in[l] = head_in[l] + IDX_W'(1);
               end
            end
         end
      end else if (accept && req_mode == MODE_RESTART) begin
         scan_in = '0;
      end
      rd_addr = ADDR_W'(int'(p_from_in) * QUEUE_DEPTH + int'(pop_idx));

      if (accept) begin
         p_valid_in = (req_mode == MODE_ADD) || (req_mode == MODE_DISPATCH);
      end else begin
         p_valid_in = p_valid_ff && !s2_fire;
      end

      // result of the push stage
      rsp_id_in    = '0;
      rsp_burst_in = '0;
      rsp_from_in  = '0;
      rsp_to_in    = '0;
      if (p_mode_ff == MODE_ADD) begin
         rsp_status_in = push_ok ? ST_ADDED : ST_ADD_FULL;
      end else if (!p_found_ff) begin
         rsp_status_in = ST_PASS_DONE;
      end else begin
         rsp_status_in = push_ok ? ST_DISPATCHED : ST_REQ_DROP;
         rsp_id_in     = rec[REC_W-1:BURST_W];
         rsp_burst_in  = rec[BURST_W-1:0];
         rsp_from_in   = 2'(p_from_ff);
         rsp_to_in     = 2'(to_lvl);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff    <= THRESH_RESET;
         ne_ff        <= '0;
         scan_ff      <= '0;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int l = 0; l < NUM_LEVELS; l++) begin
            head_ff[l] <= '0;
            tail_ff[l] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            thresh_ff <= csr_wr_data;
         end
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         ne_ff      <= ne_in;
         scan_ff    <= scan_in;
         p_valid_ff <= p_valid_in;
         if (s2_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p_mode_ff  <= req_mode;
         p_id_ff    <= req_proc_id;
         p_burst_ff <= req_burst_len;
         p_prio_ff  <= req_priority_req;
         p_found_ff <= p_found_in;
         p_from_ff  <= p_from_in;
      end
      if (s2_fire) begin
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_burst_ff  <= rsp_burst_in;
         rsp_from_ff   <= rsp_from_in;
         rsp_to_ff     <= rsp_to_in;
      end
   end

   // record memory, write-first bypass on a same-cycle address match
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff    <= entry_mem[rd_addr];
         byp_ff      <= wr_en && (wr_addr == rd_addr);
         byp_data_ff <= wr_data;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_id     = rsp_id_ff;
   assign rsp_out_burst  = rsp_burst_ff;
   assign rsp_from_level = rsp_from_ff;
   assign rsp_to_level   = rsp_to_ff;

`ifndef SYNTHESIS
   a_push_stage_drains: assert property (@(posedge clock) disable iff (reset)
      (p_valid_ff && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("push stage beat not delivered");

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      int'(scan_ff) <= NUM_LEVELS)
      else $error("scan pointer out of range");

   a_level_moves: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_DISPATCHED || rsp_status_ff == ST_REQ_DROP))
      |-> (rsp_from_ff != rsp_to_ff))
      else $error("requeue level equals source level");

   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_DISPATCHED && rsp_status_ff != ST_REQ_DROP)
      |-> (rsp_id_ff == '0 && rsp_burst_ff == '0 && rsp_from_ff == '0 && rsp_to_ff == '0))
      else $error("non-dispatch beat carries record fields");

   a_empty_level_reset: assert property (@(posedge clock) disable iff (reset)
      (ne_ff[0] == 1'b0) |-> (head_ff[0] == '0 && tail_ff[0] == '0))
      else $error("empty level keeps stale indexes");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking bench for the multilevel feedback queue scheduler core
// a scoreboard class tracks the level queues and checks each rsp beat in order
// depends on mlfq_pkg and multilevel_feedback_queue_scheduler_core
module tb;
   import mlfq_pkg::*;

   localparam logic [1:0] MODE_UNUSED  = 2'd3;
   localparam logic [1:0] LEVEL_BAD    = 2'd3;
   localparam int         QUIET_LIMIT  = 4000;
   localparam int         DRAIN_CYCLES = 8;
   localparam int         HOLD_CYCLES  = 120;

   typedef struct packed {
      logic [2:0]         status;
      logic [ID_W-1:0]    id;
      logic [BURST_W-1:0] burst;
      logic [1:0]         from_lvl;
      logic [1:0]         to_lvl;
   } rsp_beat_type;

   class mlfq_scoreboard_type;
      logic [REC_W-1:0]   slots [NUM_LEVELS][QUEUE_DEPTH];
      int unsigned        head_idx [NUM_LEVELS];
      int unsigned        tail_idx [NUM_LEVELS];
      bit                 level_live [NUM_LEVELS];
      int unsigned        scan_ptr;
      logic [BURST_W-1:0] threshold;
      rsp_beat_type       due_beats [$];
      int                 errors;

      function new();
         foreach (head_idx[l]) begin
            head_idx[l]   = 0;
            tail_idx[l]   = 0;
            level_live[l] = 0;
         end
         scan_ptr  = 0;
         threshold = THRESH_RESET;
         errors    = 0;
      endfunction

      // linear queue: full once the tail sits on the last slot
      function bit enqueue(int unsigned lvl, logic [REC_W-1:0] rec);
         if (level_live[lvl]) begin
            if (tail_idx[lvl] >= QUEUE_DEPTH - 1)
               return 0;
            tail_idx[lvl]++;
         end else begin
            head_idx[lvl]   = 0;
            tail_idx[lvl]   = 0;
            level_live[lvl] = 1;
         end
         slots[lvl][tail_idx[lvl]] = rec;
         return 1;
      endfunction

      function logic [REC_W-1:0] dequeue(int unsigned lvl);
         logic [REC_W-1:0] rec;
         rec = slots[lvl][head_idx[lvl]];
         if (head_idx[lvl] == tail_idx[lvl]) begin
            level_live[lvl] = 0;
            head_idx[lvl]   = 0;
            tail_idx[lvl]   = 0;
         end else begin
            head_idx[lvl]++;
         end
         return rec;
      endfunction

      function void schedule(logic [1:0] mode, logic [ID_W-1:0] id,
                             logic [BURST_W-1:0] burst, logic [1:0] prio);
         rsp_beat_type     beat;
         logic [REC_W-1:0] rec;
         int unsigned      dest_lvl;
         beat = '0;
         case (mode)
            MODE_ADD: begin
               beat.status = ST_ADD_FULL;
               if (prio < NUM_LEVELS) begin
                  if (enqueue(prio, {id, burst}))
                     beat.status = ST_ADDED;
               end
               due_beats.push_back(beat);
            end
            MODE_DISPATCH: begin
               while (scan_ptr < NUM_LEVELS && !level_live[scan_ptr])
                  scan_ptr++;
               if (scan_ptr >= NUM_LEVELS) begin
                  beat.status = ST_PASS_DONE;
               end else begin
                  rec = dequeue(scan_ptr);
                  if (rec[BURST_W-1:0] > threshold)
                     dest_lvl = (scan_ptr + 1) % NUM_LEVELS;
                  else
                     dest_lvl = (scan_ptr + NUM_LEVELS - 1) % NUM_LEVELS;
                  beat.status   = enqueue(dest_lvl, rec) ? ST_DISPATCHED : ST_REQ_DROP;
                  beat.id       = rec[REC_W-1:BURST_W];
                  beat.burst    = rec[BURST_W-1:0];
                  beat.from_lvl = scan_ptr[1:0];
                  beat.to_lvl   = dest_lvl[1:0];
               end
               due_beats.push_back(beat);
            end
            MODE_RESTART: scan_ptr = 0;
            default: ;
         endcase
      endfunction

      function bit field_ok(string name, logic [15:0] want, logic [15:0] got);
         if (want === got)
            return 1;
         $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
         return 0;
      endfunction

      function void check_beat(rsp_beat_type got);
         rsp_beat_type want;
         bit           ok;
         if (due_beats.size() == 0) begin
            $display("%0t unexpected rsp beat: expected none actual status %0d id %0d",
                     $time, got.status, got.id);
            errors++;
            return;
         end
         want = due_beats.pop_front();
         ok = field_ok("status", want.status, got.status)
            & field_ok("out_id", want.id, got.id)
            & field_ok("out_burst", want.burst, got.burst)
            & field_ok("from_level", want.from_lvl, got.from_lvl)
            & field_ok("to_level", want.to_lvl, got.to_lvl);
         if (!ok)
            errors++;
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_mode;
   logic [ID_W-1:0]    req_proc_id;
   logic [BURST_W-1:0] req_burst_len;
   logic [1:0]         req_priority_req;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [2:0]         rsp_status;
   logic [ID_W-1:0]    rsp_out_id;
   logic [BURST_W-1:0] rsp_out_burst;
   logic [1:0]         rsp_from_level;
   logic [1:0]         rsp_to_level;
   logic               csr_wr_en;
   logic [BURST_W-1:0] csr_wr_data;

   mlfq_scoreboard_type sb;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   bit hold_req       = 0;
   int quiet_cycles   = 0;
   int sent_count     = 0;

   multilevel_feedback_queue_scheduler_core dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 0;
            repeat (HOLD_CYCLES) begin
               rsp_ready <= 1'b0;
               @(posedge clock);
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_beat({rsp_status, rsp_out_id, rsp_out_burst, rsp_from_level, rsp_to_level});
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input logic [1:0] mode, input logic [ID_W-1:0] id,
                            input logic [BURST_W-1:0] burst, input logic [1:0] prio);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_proc_id      <= id;
      req_burst_len    <= burst;
      req_priority_req <= prio;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      sb.schedule(mode, id, burst, prio);
      if (mode != MODE_UNUSED)
         sent_count++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.due_beats.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [BURST_W-1:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.threshold = value;
   endtask

   function automatic logic [BURST_W-1:0] pick_burst();
      logic [BURST_W-1:0] t;
      t = sb.threshold;
      case ($urandom_range(0, 5))
         0: return t;
         1: return t + 1'b1;
         2: return t - 1'b1;
         3: return '0;
         4: return '1;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [1:0] pick_level();
      if ($urandom_range(0, 19) == 0)
         return LEVEL_BAD;
      return 2'($urandom_range(0, NUM_LEVELS - 1));
   endfunction

   task automatic random_item();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45)
         send_item(MODE_ADD, 8'($urandom), pick_burst(), pick_level());
      else if (r < 85)
         send_item(MODE_DISPATCH, 8'($urandom), 16'($urandom), 2'($urandom));
      else if (r < 95)
         send_item(MODE_RESTART, 8'($urandom), 16'($urandom), 2'($urandom));
      else
         send_item(MODE_UNUSED, 8'($urandom), 16'($urandom), 2'($urandom));
   endtask

   task automatic random_traffic(input int target);
      int start;
      int n;
      int lvl;
      int r;
      start = sent_count;
      while (sent_count - start < target) begin
         r = $urandom_range(0, 9);
         if (r < 3) begin
            // pile records into one level, often past full
            lvl = $urandom_range(0, NUM_LEVELS - 1);
            n = $urandom_range(4, QUEUE_DEPTH + 2);
            repeat (n) send_item(MODE_ADD, 8'($urandom), pick_burst(), lvl[1:0]);
         end else if (r < 6) begin
            if ($urandom_range(0, 3) != 0)
               send_item(MODE_RESTART, 8'($urandom), 16'($urandom), 2'($urandom));
            n = $urandom_range(3, 20);
            repeat (n) send_item(MODE_DISPATCH, 8'($urandom), 16'($urandom), 2'($urandom));
         end else if (r < 9) begin
            n = $urandom_range(5, 15);
            repeat (n) random_item();
         end else begin
            n = $urandom_range(1, 4);
            repeat (n) begin
               case ($urandom_range(0, 2))
                  0: send_item(MODE_UNUSED, 8'($urandom), 16'($urandom), 2'($urandom));
                  1: send_item(MODE_ADD, 8'($urandom), 16'($urandom), LEVEL_BAD);
                  default: send_item(MODE_RESTART, 8'($urandom), 16'($urandom),
                                     2'($urandom));
               endcase
            end
         end
      end
   endtask

   initial begin
      sb = new();
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_mode         <= MODE_ADD;
      req_proc_id      <= '0;
      req_burst_len    <= '0;
      req_priority_req <= '0;
      csr_wr_en        <= 1'b0;
      csr_wr_data      <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: empty pass, adds at field extremes, wraparound moves, restart
      send_item(MODE_DISPATCH, 8'h00, 16'h0000, 2'd0);
      send_item(MODE_DISPATCH, 8'hFF, 16'hFFFF, 2'd3);
      send_item(MODE_RESTART, 8'h00, 16'h0000, 2'd0);
      send_item(MODE_ADD, 8'h00, 16'h0000, 2'd0);
      send_item(MODE_ADD, 8'hFF, 16'hFFFF, 2'd1);
      send_item(MODE_ADD, 8'hA5, THRESH_RESET, 2'd2);
      send_item(MODE_ADD, 8'h5A, THRESH_RESET + 1'b1, 2'd2);
      send_item(MODE_ADD, 8'h3C, 16'h1234, LEVEL_BAD);
      send_item(MODE_UNUSED, 8'hFF, 16'hFFFF, 2'd3);
      repeat (7) send_item(MODE_DISPATCH, 8'h00, 16'h0000, 2'd0);
      send_item(MODE_RESTART, 8'hFF, 16'hFFFF, 2'd3);
      repeat (4) send_item(MODE_DISPATCH, 8'h00, 16'h0000, 2'd0);

      write_threshold(16'h0000);
      random_traffic(200);

      send_idle_pct = 47;
      write_threshold(16'hFFFF);
      random_traffic(200);

      send_idle_pct  = 0;
      recv_stall_pct = 47;
      write_threshold(16'($urandom));
      random_traffic(200);

      send_idle_pct  = 9;
      recv_stall_pct = 9;
      write_threshold(THRESH_RESET);
      random_traffic(200);

      // long receiver hold-off while the sender keeps pushing
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_threshold(16'($urandom_range(0, 2000)));
      hold_req = 1;
      repeat (40) send_item(MODE_ADD, 8'($urandom), pick_burst(), 2'($urandom_range(0, 2)));
      random_traffic(160);

      wait_drained();
      if (sb.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
